>>> hdl/frame_gc_window_percent_assert.svh
// assertion macros used by the frame gc window percent block
`ifndef FRAME_GC_WINDOW_PERCENT_ASSERT_SVH
`define FRAME_GC_WINDOW_PERCENT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FGCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FGCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fgcw_pkg.sv
// types and constants of the in-frame gc window counter
package fgcw_pkg;

  localparam int BASE_W = 8;
  localparam int LEN_W  = 13;
  localparam int CNT_W  = 11;
  localparam int PCT_W  = 17;
  localparam int PROD_W = CNT_W + PCT_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [BASE_W-1:0] CHAR_G = 8'd71;
  localparam logic [BASE_W-1:0] CHAR_C = 8'd67;

  localparam logic [CNT_W-1:0] CNT_MAX = 11'h7FF;
  localparam logic [PCT_W-1:0] PCT_MAX = 17'h1FFFF;
  // 300 percent-of-frame in q8 is 300 * 256
  localparam logic [PCT_W-1:0] PCT_SCALE = 17'd76800;

  localparam logic [1:0] PHASE_LAST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH   = 2'd3;

  localparam logic [LEN_W-1:0] WINDOW_RESET = 13'd100;
  localparam logic [LEN_W-1:0] STEP_RESET   = 13'd10;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              region_start;
  } in_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] gc_count;
    logic [PCT_W-1:0] percent_q8;
  } out_beat_t;

  // one step of the restoring divider: remainder and dividend/quotient shifter
  typedef struct packed {
    logic             vld;
    logic [LEN_W-1:0] rem;
    logic [PCT_W-1:0] dq;
  } div_stage_t;

endpackage

>>> hdl/fgcw_ram.sv
// generic simple dual-port ram, registered read, old data on collision
module fgcw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/fgcw_div_cell.sv
// one restoring-division cell: one quotient bit per cycle
module fgcw_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fgcw_pkg::LEN_W-1:0] divisor,
  input  fgcw_pkg::div_stage_t      stage_in,
  output fgcw_pkg::div_stage_t      stage_out
);
  import fgcw_pkg::*;

  logic             vld_r;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [PCT_W-1:0] dq_r, dq_nxt;
  logic [LEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {stage_in.rem, stage_in.dq[PCT_W-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
    dq_nxt  = {stage_in.dq[PCT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= stage_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign stage_out = '{vld: vld_r, rem: rem_r, dq: dq_r};

endmodule

>>> hdl/fgcw_div_chain.sv
// row of division cells, one quotient bit per cell
module fgcw_div_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fgcw_pkg::LEN_W-1:0] divisor,
  input  fgcw_pkg::div_stage_t      stage_in,
  output fgcw_pkg::div_stage_t      stage_out
);
  import fgcw_pkg::*;

  div_stage_t link [PCT_W+1];

  assign link[0] = stage_in;

  for (genvar i = 0; i < PCT_W; i++) begin : g_cell
    fgcw_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (divisor),
      .stage_in  (link[i]),
      .stage_out (link[i+1])
    );
  end

  assign stage_out = link[PCT_W];

endmodule

>>> hdl/frame_gc_window_percent.sv
// in-frame g/c sliding window counter with percent output, one reading frame
//
// usage: one nucleotide byte per input beat on in_valid/in_stall/in_data;
// region_start marks the first base of a region and clears the running state.
// a result beat on out_valid/out_stall/out_data carries the g/c count of each
// completed window and count*300/window in unsigned q8, truncated and clamped.
// configuration through cfg_we/cfg_index/cfg_data while the block is idle.
// timing: a base that closes no window passes the flag ring read, then the
// count update. a base that closes a window passes update, multiply, load
// (held while the output slot is taken), the divider cell row with one
// quotient bit per cell, then the output register. the next base is taken
// once the result sits in the output register, so one division at a time.
// reset: registers go to frame 0, phase 0, window 100, step 10; counters clear.
// the flag ring needs no clearing, every entry read in a region was written in
// it. a stalled output holds its beat; a new result waits for the slot to free.
`include "frame_gc_window_percent_assert.svh"

module frame_gc_window_percent #(
  parameter int WINDOW_MAX = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fgcw_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fgcw_pkg::out_beat_t           out_data,
  input  logic                          cfg_we,
  input  logic [fgcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fgcw_pkg::LEN_W-1:0]    cfg_data
);
  import fgcw_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW_MAX);
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;

  // configuration
  logic [1:0]       frame_off_r, start_ph_r;
  logic [LEN_W-1:0] win_len_r, step_len_r;
  logic [LEN_W-1:0] win_c, step_c;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]  cd_r, cd_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic              flag_r, drop_r, sat_r;
  logic [CNT_W-1:0]  res_cnt_r;
  logic [PROD_W-1:0] prod_r;
  out_beat_t         out_data_r;

  // beat decode
  logic              accept, first, flag_in, drop_in;
  logic [PTR_W-1:0]  ptr_eff, old_addr;
  logic [FILL_W-1:0] fill_eff;
  logic [1:0]        phase_eff;
  logic [31:0]       old_wide;

  // update stage
  logic              ring_q, emit, load_out;
  logic [CNT_W-1:0]  cnt_a, cnt_b;
  logic [FILL_W-1:0] fill_inc;
  logic [LEN_W-1:0]  step_m1;

  div_stage_t chain_in, chain_out;

  // zero acts as one, anything past the ring depth acts as the ring depth
  always_comb begin
    if (win_len_r == '0) begin
      win_c = LEN_W'(1);
    end else if (32'(win_len_r) > WINDOW_MAX) begin
      win_c = LEN_W'(WINDOW_MAX);
    end else begin
      win_c = win_len_r;
    end
    if (step_len_r == '0) begin
      step_c = LEN_W'(1);
    end else if (32'(step_len_r) > WINDOW_MAX) begin
      step_c = LEN_W'(WINDOW_MAX);
    end else begin
      step_c = step_len_r;
    end
  end

  assign accept = in_valid && !in_stall;
  assign first  = in_data.region_start;

  always_comb begin
    ptr_eff   = first ? '0 : ptr_r;
    fill_eff  = first ? '0 : fill_r;
    phase_eff = phase_r;
    if (first) begin
      phase_eff = (start_ph_r > PHASE_LAST) ? 2'd0 : start_ph_r;
    end
    flag_in = ((in_data.base == CHAR_G) || (in_data.base == CHAR_C)) &&
              (phase_eff == frame_off_r);
    drop_in = 32'(fill_eff) >= 32'(win_c);
    // entry leaving the window, wrapping round the ring
    if (32'(ptr_eff) >= 32'(win_c)) begin
      old_wide = 32'(ptr_eff) - 32'(win_c);
    end else begin
      old_wide = 32'(ptr_eff) + 32'(WINDOW_MAX) - 32'(win_c);
    end
    old_addr = old_wide[PTR_W-1:0];
  end

  fgcw_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW_MAX)
  ) u_flag_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (ptr_eff),
    .wr_data (flag_in),
    .rd_en   (accept),
    .rd_addr (old_addr),
    .rd_data (ring_q)
  );

  always_comb begin
    cnt_a = (drop_r && ring_q && (cnt_r != '0)) ? cnt_r - CNT_W'(1) : cnt_r;
    cnt_b = (flag_r && (cnt_a != CNT_MAX)) ? cnt_a + CNT_W'(1) : cnt_a;
    fill_inc = (32'(fill_r) == WINDOW_MAX) ? fill_r : fill_r + FILL_W'(1);
    step_m1  = step_c - LEN_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    fill_nxt      = fill_r;
    cd_nxt        = cd_r;
    out_valid_nxt = out_valid_r && out_stall;
    emit          = 1'b0;
    load_out      = 1'b0;
    chain_in      = '{vld: 1'b0, rem: LEN_W'(prod_r[PROD_W-1:PCT_W]),
                      dq: prod_r[PCT_W-1:0]};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ptr_nxt   = ptr_eff;
          fill_nxt  = fill_eff;
          phase_nxt = (phase_eff == PHASE_LAST) ? 2'd0 : phase_eff + 2'd1;
          if (first) begin
            cnt_nxt = '0;
            cd_nxt  = '0;
          end
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cnt_nxt   = cnt_b;
        ptr_nxt   = (32'(ptr_r) == WINDOW_MAX - 1) ? '0 : ptr_r + PTR_W'(1);
        fill_nxt  = fill_inc;
        state_nxt = S_IDLE;
        if (32'(fill_inc) >= 32'(win_c)) begin
          if (cd_r == '0) begin
            emit      = 1'b1;
            cd_nxt    = PTR_W'(step_m1);
            state_nxt = S_MUL;
          end else begin
            cd_nxt = cd_r - PTR_W'(1);
          end
        end
      end
      S_MUL: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // start a division only when the output slot is free to take it
        if (!out_valid_r) begin
          chain_in.vld = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (chain_out.vld) begin
          out_valid_nxt = 1'b1;
          load_out      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  fgcw_div_chain u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .divisor   (win_c),
    .stage_in  (chain_in),
    .stage_out (chain_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_off_r <= 2'd0;
      start_ph_r  <= 2'd0;
      win_len_r   <= WINDOW_RESET;
      step_len_r  <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_OFFSET:  frame_off_r <= cfg_data[1:0];
        REG_START_PHASE:   start_ph_r  <= cfg_data[1:0];
        REG_WINDOW_LENGTH: win_len_r   <= cfg_data;
        REG_STEP_LENGTH:   step_len_r  <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      cnt_r       <= '0;
      phase_r     <= 2'd0;
      fill_r      <= '0;
      cd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      cd_r        <= cd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flag_r <= flag_in;
      drop_r <= drop_in;
    end
    if (emit) begin
      res_cnt_r <= cnt_b;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(res_cnt_r) * PROD_W'(PCT_SCALE);
    end
    // quotient past 17 bits exactly when the top product bits reach the window
    if (chain_in.vld) begin
      sat_r <= LEN_W'(prod_r[PROD_W-1:PCT_W]) >= win_c;
    end
    if (load_out) begin
      out_data_r.gc_count   <= res_cnt_r;
      out_data_r.percent_q8 <= sat_r ? PCT_MAX : chain_out.dq;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FGCW_ASSERT_IMP(a_div_only_waiting, chain_out.vld, state_r == S_DIV,
    "divider result arrived outside the wait state")
  `FGCW_ASSERT_IMP(a_out_from_div, $rose(out_valid_r), $past(state_r) == S_DIV,
    "output beat raised without a finished division")
  `FGCW_ASSERT_NEXT(a_start_needs_room, chain_in.vld, out_valid_r == 1'b0,
    "division started while the output slot was taken")
  `FGCW_ASSERT_IMP(a_ptr_bound, 1'b1, 32'(ptr_r) < WINDOW_MAX,
    "ring pointer beyond the ring depth")
  `FGCW_ASSERT_IMP(a_fill_bound, 1'b1, 32'(fill_r) <= WINDOW_MAX,
    "fill count beyond the ring depth")

endmodule

>>> test/frame_gc_window_percent_tb.sv
// testbench for the in-frame g/c sliding window counter: predicts every window result and checks it
module frame_gc_window_percent_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fgcw_pkg::*;

  localparam int RING_DEPTH = 4096;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BASES = 150;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_OFFSET;
  logic [LEN_W-1:0] cfg_data = '0;

  // shadow registers
  logic [1:0] frame_sel = 2'd0;
  logic [1:0] phase_sel = 2'd0;
  logic [LEN_W-1:0] win_reg = WINDOW_RESET;
  logic [LEN_W-1:0] step_reg = STEP_RESET;

  // predicted counter state
  bit flag_mem [RING_DEPTH];
  logic [11:0] ring_ptr = '0;
  logic [CNT_W-1:0] gc_run = '0;
  logic [1:0] pos_phase = 2'd0;
  logic [LEN_W-1:0] bases_filled = '0;
  logic [11:0] steps_left = '0;

  out_beat_t window_q[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int bases_sent = 0;
  int windows_checked = 0;
  int settings_used = 0;
  int hold_offs = 0;

  frame_gc_window_percent #(.WINDOW_MAX(RING_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // zero acts as one, anything past the ring acts as the ring depth
  function automatic int unsigned eff_len(input logic [LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > RING_DEPTH) return RING_DEPTH;
    return v;
  endfunction

  function automatic void predict_window(input in_beat_t b);
    int unsigned w;
    int unsigned s;
    int unsigned old_idx;
    bit hit;
    longint unsigned pct;
    out_beat_t r;
    w = eff_len(win_reg);
    s = eff_len(step_reg);
    if (b.region_start) begin
      gc_run = '0;
      bases_filled = '0;
      steps_left = '0;
      ring_ptr = '0;
      pos_phase = (phase_sel > PHASE_LAST) ? 2'd0 : phase_sel;
    end
    hit = (b.base == CHAR_G || b.base == CHAR_C) && pos_phase == frame_sel;
    if (bases_filled >= w) begin
      old_idx = (ring_ptr + RING_DEPTH - w) % RING_DEPTH;
      if (flag_mem[old_idx] && gc_run != '0) gc_run = gc_run - 1'b1;
    end
    flag_mem[ring_ptr] = hit;
    if (hit && gc_run != CNT_MAX) gc_run = gc_run + 1'b1;
    ring_ptr = ring_ptr + 1'b1;
    pos_phase = (pos_phase == PHASE_LAST) ? 2'd0 : pos_phase + 2'd1;
    if (bases_filled < RING_DEPTH) bases_filled = bases_filled + 1'b1;
    if (bases_filled >= w) begin
      if (steps_left == '0) begin
        pct = (64'(gc_run) * 64'(PCT_SCALE)) / w;
        if (pct > PCT_MAX) pct = PCT_MAX;
        r.gc_count = gc_run;
        r.percent_q8 = pct[PCT_W-1:0];
        window_q.push_back(r);
        steps_left = 12'(s - 1);
      end else begin
        steps_left = steps_left - 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (window_q.size() == 0) begin
        report_mismatch($sformatf("result beat with no window pending (count %0d)",
                                  out_data.gc_count));
      end else begin
        want = window_q.pop_front();
        if (out_data.gc_count !== want.gc_count)
          report_mismatch($sformatf("result %0d gc_count %0d, predicted %0d",
                                    windows_checked, out_data.gc_count, want.gc_count));
        if (out_data.percent_q8 !== want.percent_q8)
          report_mismatch($sformatf("result %0d percent_q8 %0d, predicted %0d",
                                    windows_checked, out_data.percent_q8, want.percent_q8));
      end
      windows_checked++;
    end
  end

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin gap_pct = 46; stall_pct = 0;  end
      IDLE_RECV: begin gap_pct = 0;  stall_pct = 46; end
      default:   begin gap_pct = 14; stall_pct = 14; end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FRAME_OFFSET:  frame_sel = val[1:0];
      REG_START_PHASE:   phase_sel = val[1:0];
      REG_WINDOW_LENGTH: win_reg = val;
      default:           step_reg = val;
    endcase
  endtask

  task automatic set_config(input logic [LEN_W-1:0] fo, input logic [LEN_W-1:0] sp,
                            input logic [LEN_W-1:0] wl, input logic [LEN_W-1:0] sl);
    write_reg(REG_FRAME_OFFSET, fo);
    write_reg(REG_START_PHASE, sp);
    write_reg(REG_WINDOW_LENGTH, wl);
    write_reg(REG_STEP_LENGTH, sl);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_base(input logic [BASE_W-1:0] b, input bit opens);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{base: b, region_start: opens};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_window(in_data);
    bases_sent++;
  endtask

  // sender goes quiet until every pending window has come out
  task automatic drain_windows();
    in_valid <= 1'b0;
    @(posedge clk);
    while (window_q.size() != 0) @(posedge clk);
  endtask

  task automatic finish_phase();
    drain_windows();
    // a base that closes no window may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // g/c in four of ten, lowercase g/c in one, the rest any byte
  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(9, 0))
      0, 1:    return CHAR_G;
      2, 3:    return CHAR_C;
      4:       return $urandom_range(1, 0) ? 8'd103 : 8'd99;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // reset registers, and bases arrive before any region start
  task automatic test_reset_state();
    set_idle(IDLE_NONE);
    for (int i = 0; i < 160; i++)
      send_base(pick_base(), (i >= 120) && ($urandom_range(15, 0) == 0));
    finish_phase();
  endtask

  task automatic test_directed_frames();
    set_idle(IDLE_NONE);
    set_config(13'd1, 13'd2, 13'd3, 13'd0);
    send_base(CHAR_G, 1'b1);
    send_base(CHAR_C, 1'b0);
    send_base(CHAR_G, 1'b0);
    send_base(8'd103, 1'b0);
    send_base(8'd99, 1'b0);
    send_base(8'd0, 1'b0);
    send_base(8'd255, 1'b0);
    // restart mid-stream
    send_base(CHAR_C, 1'b1);
    send_base(CHAR_G, 1'b0);
    send_base(CHAR_C, 1'b0);
    finish_phase();
    // frame three never matches, phase three acts as zero, window zero acts as one
    set_config(13'd3, 13'd3, 13'd0, 13'h1FFF);
    send_base(CHAR_G, 1'b1);
    send_base(CHAR_C, 1'b0);
    send_base(CHAR_G, 1'b0);
    send_base(CHAR_C, 1'b0);
    finish_phase();
  endtask

  // shrink the window inside a region so the count outgrows it and the percent clamps
  task automatic test_percent_clamp();
    set_idle(IDLE_RECV);
    set_config(13'd0, 13'd0, 13'd9, 13'd1);
    for (int i = 0; i < 9; i++) send_base(CHAR_G, i == 0);
    finish_phase();
    set_config(13'd0, 13'd0, 13'd1, 13'd1);
    send_base(8'd65, 1'b0);
    send_base(8'd65, 1'b0);
    finish_phase();
  endtask

  // window past the depth gives nothing yet, then a long window with the region carried on
  task automatic test_full_window();
    set_idle(IDLE_BOTH);
    set_config(13'd2, 13'd1, 13'h1FFF, 13'd0);
    for (int i = 0; i < 60; i++) send_base(pick_base(), i == 0);
    finish_phase();
    set_config(13'd0, 13'd2, 13'd250, 13'd0);
    for (int i = 0; i < 300; i++) send_base(pick_base(), 1'b0);
    finish_phase();
  endtask

  task automatic test_random_settings();
    logic [LEN_W-1:0] wl;
    logic [LEN_W-1:0] sl;
    bit opens;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idle(idle_mode_t'(p % 4));
      case ($urandom_range(9, 0))
        0:       wl = '0;
        1:       wl = LEN_W'($urandom_range(120, 30));
        default: wl = LEN_W'($urandom_range(24, 1));
      endcase
      case ($urandom_range(9, 0))
        0:       sl = '0;
        1:       sl = LEN_W'($urandom_range(40, 9));
        default: sl = LEN_W'($urandom_range(8, 1));
      endcase
      set_config(LEN_W'($urandom_range(3, 0)), LEN_W'($urandom_range(3, 0)), wl, sl);
      for (int i = 0; i < PHASE_BASES; i++) begin
        if (i > 0 && $urandom_range(99, 0) == 0) begin
          drain_windows();
          hold_offs++;
        end
        // about a quarter of the phases after the first carry the previous region on under new registers
        if (i == 0) opens = (p == 0) || ($urandom_range(3, 0) != 0);
        else opens = ($urandom_range(63, 0) == 0);
        send_base(pick_base(), opens);
      end
      finish_phase();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_frames();
    test_percent_clamp();
    test_random_settings();
    test_full_window();
    in_valid <= 1'b0;
    @(posedge clk);
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d bases under %0d register settings, %0d window results checked",
             bases_sent, settings_used, windows_checked);
    $display("sender held off until drained %0d times, %0d mismatches", hold_offs, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("timeout with %0d windows pending", window_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
